// ----- hdl/wrb_pkg.sv -----
package wrb_pkg;

   typedef enum logic [1:0] {
      OP_ADD     = 2'd0,
      OP_ADVANCE = 2'd1,
      OP_RELEASE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_ACCEPTED = 3'd0,
      KIND_DROPPED  = 3'd1,
      KIND_WM_ACK   = 3'd2,
      KIND_RELEASED = 3'd3,
      KIND_NONE     = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_UP,
      ST_INS_CMP,
      ST_REL_RD,
      ST_REL_CHK,
      ST_POP_LAST,
      ST_POP_RD,
      ST_POP_RR,
      ST_POP_CMP
   } state_type;

   localparam int unsigned REG_LATENESS = 0;
   localparam int unsigned REG_LIMIT    = 1;
   localparam logic [31:0] LATENESS_RESET = 32'd30;
   localparam logic [6:0]  LIMIT_RESET    = 7'd64;
   localparam logic [31:0] CNT_MAX        = 32'hFFFF_FFFF;

endpackage

// ----- hdl/watermark_reorder_buffer.sv -----
// channel | direction | accepted when          | fields
// req     | in        | start & !busy          | operation, timestamp, payload
// rsp     | out       | rsp_valid, one cycle   | kind, item_time, item_data, flushed, last,
//         |           |                        | current_watermark, buffered_count, totals
// csr     | in        | csr_valid & csr_ready  | csr_index, csr_data
// drop, advance and the unused op stay idle; the first two beat the cycle after accept
// add: the new item sifts up; per level the parent is read and compared, and a larger
// parent moves down; release reads and tests the head, and each released item moves the
// tail entry to the root, which sinks as each level reads its children and compares;
// an item's beat leaves once the next head is tested
// reset is synchronous and clears control state and counters; heap contents follow the size
// the receiver cannot stall; csr_ready is low while busy or while start is high
module watermark_reorder_buffer #(
   parameter int BUFFER_DEPTH = 64,
   parameter int TIME_BITS    = 32,
   parameter int DATA_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_timestamp,
   input  logic [31:0] req_payload,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_item_time,
   output logic [31:0] rsp_item_data,
   output logic        rsp_flushed,
   output logic        rsp_last,
   output logic [31:0] rsp_current_watermark,
   output logic [6:0]  rsp_buffered_count,
   output logic [31:0] rsp_dropped_total,
   output logic [31:0] rsp_released_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int EW = TIME_BITS + DATA_BITS;
   localparam int CW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
   localparam logic [6:0] DEPTH7 = 7'(BUFFER_DEPTH);

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [DATA_BITS-1:0] data_type;

   logic [EW-1:0] heap_mem [BUFFER_DEPTH];
   logic [EW-1:0] rd_data_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   wrb_pkg::state_type state_ff, state_in;
   logic [6:0]  size_ff, size_in;
   time_type    wm_ff, wm_in;
   time_type    max_ff, max_in;
   logic [31:0] drop_ff, drop_in;
   logic [31:0] rel_ff, rel_in;
   logic [31:0] late_ff, late_in;
   logic [6:0]  limit_ff, limit_in;
   logic [6:0]  idx_ff, idx_in;      // hole position
   time_type    key_ff, key_in;      // entry being sifted
   data_type    val_ff, val_in;
   time_type    ctime_ff, ctime_in;  // left child during sift down
   data_type    cdata_ff, cdata_in;
   logic        has_r_ff, has_r_in;
   logic        fl_ff, fl_in;
   logic        pend_ff, pend_in;    // popped item waiting for its beat
   time_type    otime_ff, otime_in;
   data_type    odata_ff, odata_in;

   logic              v_ff, v_in;
   wrb_pkg::kind_type k_ff, k_in;
   logic [31:0]       it_ff, it_in, id_ff, id_in;
   logic              of_ff, of_in, ol_ff, ol_in;

   wrb_pkg::op_type op;
   time_type ts_m;
   data_type pl_m;
   time_type rd_t;
   data_type rd_d;
   time_type max_up;
   logic signed [CW-1:0] thr, nw;
   logic       late_drop, flush, head_ok, key_up, pick_r, sink;
   logic [6:0] parent, left7, right7, tail7, best_i;
   time_type   best_t;
   data_type   best_d;

   always_ff @(posedge clock) begin
      if (wr_en) heap_mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= heap_mem[rd_addr];
   end

   assign op     = wrb_pkg::op_type'(req_operation);
   assign ts_m   = TIME_BITS'(req_timestamp);
   assign pl_m   = DATA_BITS'(req_payload);
   assign rd_t   = rd_data_ff[EW-1:DATA_BITS];
   assign rd_d   = rd_data_ff[DATA_BITS-1:0];
   assign max_up = (ts_m > max_ff) ? ts_m : max_ff;
   assign thr    = $signed(CW'(wm_ff)) - $signed(CW'(late_ff));
   assign nw     = $signed(CW'(max_ff)) - $signed(CW'(late_ff));

   assign late_drop = $signed(CW'(ts_m)) < thr;
   assign flush     = (size_ff >= limit_ff) || (size_ff >= DEPTH7);
   assign head_ok   = (size_ff != 7'd0) && (rd_t <= wm_ff);
   assign key_up    = key_ff < rd_t;
   assign parent    = (idx_ff - 7'd1) >> 1;
   assign left7     = {idx_ff[5:0], 1'b1};
   assign right7    = left7 + 7'd1;
   assign tail7     = size_ff - 7'd1;
   // smaller child, left on a tie
   assign pick_r    = has_r_ff && (rd_t < ctime_ff);
   assign best_t    = pick_r ? rd_t : ctime_ff;
   assign best_d    = pick_r ? rd_d : cdata_ff;
   assign best_i    = pick_r ? right7 : left7;
   assign sink      = best_t < key_ff;

   assign busy      = (state_ff != wrb_pkg::ST_IDLE);
   assign csr_ready = !busy && !start;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wrb_pkg::ST_IDLE: begin
            if (start) begin
               case (op)
                  wrb_pkg::OP_ADD: if (!late_drop) state_in = wrb_pkg::ST_INS_UP;
                  wrb_pkg::OP_RELEASE: state_in = wrb_pkg::ST_REL_RD;
                  default: ;
               endcase
            end
         end
         wrb_pkg::ST_INS_UP: begin
            state_in = (idx_ff != 7'd0) ? wrb_pkg::ST_INS_CMP : wrb_pkg::ST_IDLE;
         end
         wrb_pkg::ST_INS_CMP: begin
            state_in = key_up ? wrb_pkg::ST_INS_UP : wrb_pkg::ST_IDLE;
         end
         wrb_pkg::ST_REL_RD: state_in = wrb_pkg::ST_REL_CHK;
         wrb_pkg::ST_REL_CHK: begin
            state_in = head_ok ? wrb_pkg::ST_POP_LAST : wrb_pkg::ST_IDLE;
         end
         wrb_pkg::ST_POP_LAST: state_in = wrb_pkg::ST_POP_RD;
         wrb_pkg::ST_POP_RD: begin
            state_in = (left7 < size_ff) ? wrb_pkg::ST_POP_RR : wrb_pkg::ST_REL_RD;
         end
         wrb_pkg::ST_POP_RR: state_in = wrb_pkg::ST_POP_CMP;
         wrb_pkg::ST_POP_CMP: begin
            state_in = sink ? wrb_pkg::ST_POP_RD : wrb_pkg::ST_REL_RD;
         end
         default: state_in = wrb_pkg::ST_IDLE;
      endcase
   end

   // datapath, memory port and result beat
   always_comb begin
      size_in = size_ff; wm_in = wm_ff; max_in = max_ff;
      drop_in = drop_ff; rel_in = rel_ff;
      late_in = late_ff; limit_in = limit_ff;
      idx_in = idx_ff; key_in = key_ff; val_in = val_ff;
      ctime_in = ctime_ff; cdata_in = cdata_ff; has_r_in = has_r_ff;
      fl_in = fl_ff; pend_in = pend_ff; otime_in = otime_ff; odata_in = odata_ff;
      rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wr_data = '0;
      v_in = 1'b0; k_in = wrb_pkg::KIND_ACCEPTED; it_in = '0; id_in = '0;
      of_in = 1'b0; ol_in = 1'b1;
      if (csr_valid && csr_ready) begin
         if (csr_index == 1'(wrb_pkg::REG_LATENESS)) late_in = csr_data;
         else limit_in = csr_data[6:0];
      end
      case (state_ff)
         wrb_pkg::ST_IDLE: begin
            if (start) begin
               case (op)
                  wrb_pkg::OP_ADD: begin
                     max_in = max_up;
                     if (late_drop) begin
                        if (drop_ff != wrb_pkg::CNT_MAX) drop_in = drop_ff + 32'd1;
                        v_in = 1'b1; k_in = wrb_pkg::KIND_DROPPED;
                     end else begin
                        key_in = ts_m; val_in = pl_m;
                        idx_in = size_ff; fl_in = 1'b0;
                        if (flush) begin
                           wm_in = max_up; size_in = '0; idx_in = '0; fl_in = 1'b1;
                        end
                     end
                  end
                  wrb_pkg::OP_ADVANCE: begin
                     if (nw > $signed(CW'(wm_ff))) wm_in = TIME_BITS'(nw);
                     v_in = 1'b1; k_in = wrb_pkg::KIND_WM_ACK;
                  end
                  wrb_pkg::OP_RELEASE: pend_in = 1'b0;
                  default: ;
               endcase
            end
         end
         wrb_pkg::ST_INS_UP: begin
            if (idx_ff == 7'd0) begin
               wr_en = 1'b1; wr_addr = '0; wr_data = {key_ff, val_ff};
               size_in = size_ff + 7'd1;
               v_in = 1'b1; k_in = wrb_pkg::KIND_ACCEPTED; of_in = fl_ff;
            end else begin
               rd_en = 1'b1; rd_addr = parent[AW-1:0];
            end
         end
         wrb_pkg::ST_INS_CMP: begin
            wr_en = 1'b1; wr_addr = idx_ff[AW-1:0];
            if (key_up) begin
               // parent moves down into the hole
               wr_data = rd_data_ff; idx_in = parent;
            end else begin
               wr_data = {key_ff, val_ff};
               size_in = size_ff + 7'd1;
               v_in = 1'b1; k_in = wrb_pkg::KIND_ACCEPTED; of_in = fl_ff;
            end
         end
         wrb_pkg::ST_REL_RD: begin
            rd_en = 1'b1; rd_addr = '0;
         end
         wrb_pkg::ST_REL_CHK: begin
            if (pend_ff) begin
               v_in = 1'b1; k_in = wrb_pkg::KIND_RELEASED;
               it_in = 32'(otime_ff); id_in = 32'(odata_ff); ol_in = !head_ok;
            end else if (!head_ok) begin
               v_in = 1'b1; k_in = wrb_pkg::KIND_NONE;
            end
            if (head_ok) begin
               otime_in = rd_t; odata_in = rd_d; pend_in = 1'b1;
               rd_en = 1'b1; rd_addr = tail7[AW-1:0];
            end
         end
         wrb_pkg::ST_POP_LAST: begin
            key_in = rd_t; val_in = rd_d;
            size_in = tail7; idx_in = '0;
            if (rel_ff != wrb_pkg::CNT_MAX) rel_in = rel_ff + 32'd1;
         end
         wrb_pkg::ST_POP_RD: begin
            if (left7 < size_ff) begin
               rd_en = 1'b1; rd_addr = left7[AW-1:0];
            end else if (size_ff != 7'd0) begin
               wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_data = {key_ff, val_ff};
            end
         end
         wrb_pkg::ST_POP_RR: begin
            ctime_in = rd_t; cdata_in = rd_d;
            has_r_in = right7 < size_ff;
            if (right7 < size_ff) begin
               rd_en = 1'b1; rd_addr = right7[AW-1:0];
            end
         end
         wrb_pkg::ST_POP_CMP: begin
            wr_en = 1'b1; wr_addr = idx_ff[AW-1:0];
            if (sink) begin
               wr_data = {best_t, best_d}; idx_in = best_i;
            end else begin
               wr_data = {key_ff, val_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wrb_pkg::ST_IDLE;
         size_ff <= '0; wm_ff <= '0; max_ff <= '0; drop_ff <= '0; rel_ff <= '0;
         late_ff <= wrb_pkg::LATENESS_RESET; limit_ff <= wrb_pkg::LIMIT_RESET;
         pend_ff <= 1'b0; v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         size_ff <= size_in; wm_ff <= wm_in; max_ff <= max_in;
         drop_ff <= drop_in; rel_ff <= rel_in;
         late_ff <= late_in; limit_ff <= limit_in;
         pend_ff <= pend_in; v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in; key_ff <= key_in; val_ff <= val_in;
      ctime_ff <= ctime_in; cdata_ff <= cdata_in; has_r_ff <= has_r_in;
      fl_ff <= fl_in; otime_ff <= otime_in; odata_ff <= odata_in;
      k_ff <= k_in; it_ff <= it_in; id_ff <= id_in; of_ff <= of_in; ol_ff <= ol_in;
   end

   // status fields are live: nothing changes them during the beat cycle
   assign rsp_valid             = v_ff;
   assign rsp_kind              = k_ff;
   assign rsp_item_time         = it_ff;
   assign rsp_item_data         = id_ff;
   assign rsp_flushed           = of_ff;
   assign rsp_last              = ol_ff;
   assign rsp_current_watermark = 32'(wm_ff);
   assign rsp_buffered_count    = size_ff;
   assign rsp_dropped_total     = drop_ff;
   assign rsp_released_total    = rel_ff;

   assert property (@(posedge clock) disable iff (reset) size_ff <= DEPTH7)
      else $error("heap size beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == wrb_pkg::KIND_DROPPED |-> rsp_last)
      else $error("drop beat without last");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == wrb_pkg::KIND_ACCEPTED |-> rsp_buffered_count != 7'd0)
      else $error("accepted beat with empty heap");
   assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |-> !busy && !start)
      else $error("register write while busy");

endmodule

// ----- tb/wrb_checker.sv -----
module wrb_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_timestamp,
   input  logic [31:0] req_payload,
   input  logic        rsp_valid,
   input  logic [2:0]  rsp_kind,
   input  logic [31:0] rsp_item_time,
   input  logic [31:0] rsp_item_data,
   input  logic        rsp_flushed,
   input  logic        rsp_last,
   input  logic [31:0] rsp_current_watermark,
   input  logic [6:0]  rsp_buffered_count,
   input  logic [31:0] rsp_dropped_total,
   input  logic [31:0] rsp_released_total,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] t;
      logic [31:0] d;
      logic        fl;
      logic        last;
      logic [31:0] wm;
      logic [6:0]  cnt;
      logic [31:0] drop;
      logic [31:0] rel;
   } result_t;

   result_t     expected_q[$];
   logic [31:0] heap_t[64];
   logic [31:0] heap_d[64];
   int          hsize;
   logic [31:0] wmark, max_seen, drops, rels, lateness;
   logic [6:0]  limit;

   function automatic result_t mk(logic [2:0] k, logic [31:0] t, logic [31:0] d,
                                  logic fl, logic last);
      result_t r;
      r.kind = k; r.t = t; r.d = d; r.fl = fl; r.last = last;
      r.wm = wmark; r.cnt = 7'(hsize); r.drop = drops; r.rel = rels;
      return r;
   endfunction

   task automatic queue_beat(result_t r);
      expected_q = {expected_q, r};
   endtask

   task automatic heap_push(logic [31:0] t, logic [31:0] d);
      int i, p;
      i = hsize;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!(t < heap_t[p])) break;
         heap_t[i] = heap_t[p]; heap_d[i] = heap_d[p];
         i = p;
      end
      heap_t[i] = t; heap_d[i] = d;
      hsize++;
   endtask

   task automatic heap_pop_min();
      int i, c;
      logic [31:0] vt, vd;
      i = 0;
      hsize--;
      vt = heap_t[hsize]; vd = heap_d[hsize];
      forever begin
         c = 2 * i + 1;
         if (c >= hsize) break;
         if (c + 1 < hsize && heap_t[c+1] < heap_t[c]) c++;
         if (!(heap_t[c] < vt)) break;
         heap_t[i] = heap_t[c]; heap_d[i] = heap_d[c];
         i = c;
      end
      if (hsize > 0) begin
         heap_t[i] = vt; heap_d[i] = vd;
      end
   endtask

   task automatic predict_beat(logic [1:0] op, logic [31:0] ts, logic [31:0] pl);
      logic signed [33:0] nw;
      logic        fl;
      logic [31:0] t, d;
      int          n;
      case (op)
         wrb_pkg::OP_ADD: begin
            fl = 1'b0;
            if (ts > max_seen) max_seen = ts;
            if ($signed({2'b0, ts}) < $signed({2'b0, wmark}) - $signed({2'b0, lateness}))
            begin
               if (drops != wrb_pkg::CNT_MAX) drops++;
               queue_beat(mk(wrb_pkg::KIND_DROPPED, 0, 0, 0, 1));
            end else begin
               if (hsize >= limit || hsize >= 64) begin
                  wmark = max_seen; hsize = 0; fl = 1'b1;
               end
               heap_push(ts, pl);
               queue_beat(mk(wrb_pkg::KIND_ACCEPTED, 0, 0, fl, 1));
            end
         end
         wrb_pkg::OP_ADVANCE: begin
            nw = $signed({2'b0, max_seen}) - $signed({2'b0, lateness});
            if (nw > $signed({2'b0, wmark})) wmark = nw[31:0];
            queue_beat(mk(wrb_pkg::KIND_WM_ACK, 0, 0, 0, 1));
         end
         wrb_pkg::OP_RELEASE: begin
            n = 0;
            while (hsize > 0 && heap_t[0] <= wmark) begin
               t = heap_t[0]; d = heap_d[0];
               heap_pop_min();
               if (rels != wrb_pkg::CNT_MAX) rels++;
               queue_beat(mk(wrb_pkg::KIND_RELEASED, t, d, 0,
                             hsize == 0 || heap_t[0] > wmark));
               n++;
            end
            if (n == 0) queue_beat(mk(wrb_pkg::KIND_NONE, 0, 0, 0, 1));
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      result_t got, exp;
      if (reset) begin
         hsize = 0; wmark = 0; max_seen = 0; drops = 0; rels = 0;
         lateness = wrb_pkg::LATENESS_RESET; limit = wrb_pkg::LIMIT_RESET;
         expected_q.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == 1'(wrb_pkg::REG_LATENESS)) lateness = csr_data;
            else limit = csr_data[6:0];
         end
         if (start && !busy) predict_beat(req_operation, req_timestamp, req_payload);
         if (rsp_valid) begin
            got = '{rsp_kind, rsp_item_time, rsp_item_data, rsp_flushed, rsp_last,
                    rsp_current_watermark, rsp_buffered_count, rsp_dropped_total,
                    rsp_released_total};
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result beat %p", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               exp = expected_q.pop_front();
               if (got !== exp) begin
                  $display("%0t: mismatch expected %p actual %p", $time, exp, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= expected_q.size();
      end
   end

endmodule

// ----- tb/tb.sv -----
module tb;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_operation = wrb_pkg::OP_ADD;
   logic [31:0] req_timestamp = 0;
   logic [31:0] req_payload = 0;
   logic        rsp_valid;
   logic [2:0]  rsp_kind;
   logic [31:0] rsp_item_time, rsp_item_data, rsp_current_watermark;
   logic        rsp_flushed, rsp_last;
   logic [6:0]  rsp_buffered_count;
   logic [31:0] rsp_dropped_total, rsp_released_total;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [0:0]  csr_index = 0;
   logic [31:0] csr_data = 0;
   int          fail_count, pending;
   int          stall_cycles = 0;
   int          idle_pct;
   logic [31:0] time_base;

   always #5 clock = ~clock;

   watermark_reorder_buffer DUT (.*);
   wrb_checker checker_i (.*);

   // watchdog: cycles with no beat on any channel
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready) || reset)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 20000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // start stays high after the accepting edge so the next beat can follow at once
   task automatic send(logic [1:0] op, logic [31:0] ts, logic [31:0] pl);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1; req_operation <= op; req_timestamp <= ts; req_payload <= pl;
      do @(posedge clock); while (busy);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [31:0] val);
      start <= 0;
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   task automatic random_item();
      int r;
      logic [31:0] ts;
      r = $urandom_range(99);
      // mostly timestamps near a slowly rising base, so drops and releases happen
      if ($urandom_range(9) == 0) ts = $urandom();
      else ts = time_base + $urandom_range(80) - 40;
      time_base = time_base + $urandom_range(6);
      if (r < 55) send(wrb_pkg::OP_ADD, ts, $urandom());
      else if (r < 72) send(wrb_pkg::OP_ADVANCE, $urandom(), $urandom());
      else if (r < 95) send(wrb_pkg::OP_RELEASE, $urandom(), $urandom());
      else send(wrb_pkg::OP_NONE, $urandom(), $urandom());
   endtask

   initial begin
      idle_pct = 0;
      time_base = 1000;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, equal timestamps, empty release, unused op
      send(wrb_pkg::OP_RELEASE, 0, 0);
      send(wrb_pkg::OP_ADVANCE, 0, 0);
      send(wrb_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(wrb_pkg::OP_ADD, 0, 0);
      send(wrb_pkg::OP_ADD, 5, 32'hA5A5_5A5A);
      send(wrb_pkg::OP_ADD, 5, 32'h5A5A_A5A5);
      send(wrb_pkg::OP_ADD, 5, 32'h1);
      send(wrb_pkg::OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(wrb_pkg::OP_ADVANCE, 0, 0);
      send(wrb_pkg::OP_RELEASE, 0, 0);
      send(wrb_pkg::OP_ADD, 0, 7);
      send(wrb_pkg::OP_RELEASE, 0, 0);
      write_reg(1'(wrb_pkg::REG_LIMIT), 1);
      send(wrb_pkg::OP_ADD, 100, 1);
      send(wrb_pkg::OP_ADD, 50, 2);
      send(wrb_pkg::OP_ADD, 200, 3);
      write_reg(1'(wrb_pkg::REG_LIMIT), 0);
      send(wrb_pkg::OP_ADD, 300, 4);
      send(wrb_pkg::OP_ADD, 10, 5);
      write_reg(1'(wrb_pkg::REG_LATENESS), 32'hFFFF_FFFF);
      send(wrb_pkg::OP_ADVANCE, 0, 0);
      send(wrb_pkg::OP_ADD, 1, 6);
      send(wrb_pkg::OP_RELEASE, 0, 0);
      write_reg(1'(wrb_pkg::REG_LIMIT), 64);
      write_reg(1'(wrb_pkg::REG_LATENESS), 0);
      time_base = 500;
      for (int ph = 0; ph < 7; ph++) begin
         case (ph % 4)
            0: idle_pct = 0;
            1: idle_pct = 70;
            2: idle_pct = 36;
            default: idle_pct = 0;
         endcase
         case (ph)
            1: write_reg(1'(wrb_pkg::REG_LATENESS), 30);
            2: write_reg(1'(wrb_pkg::REG_LIMIT), 7'($urandom_range(1, 12)));
            3: write_reg(1'(wrb_pkg::REG_LATENESS), $urandom_range(200));
            4: write_reg(1'(wrb_pkg::REG_LIMIT), 64);
            5: write_reg(1'(wrb_pkg::REG_LIMIT), 127);
            6: write_reg(1'(wrb_pkg::REG_LATENESS), 32'hFFFF_FFFF);
            default: ;
         endcase
         for (int i = 0; i < 40; i++) random_item();
         if (ph == 4) begin
            // fill to the depth with timestamps way above the base, then flush one
            for (int i = 0; i < 66; i++)
               send(wrb_pkg::OP_ADD, time_base + 5000 + $urandom_range(99), $urandom());
            send(wrb_pkg::OP_ADVANCE, 0, 0);
            send(wrb_pkg::OP_RELEASE, 0, 0);
         end
      end
      start <= 0;
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- watermark_reorder_buffer.f -----
hdl/wrb_pkg.sv
hdl/watermark_reorder_buffer.sv
tb/wrb_checker.sv
tb/tb.sv
